FILE: src/usart_register_model_assert.svh
// Assertion macros shared by the register model.
// They sample on aclk and are ignored while aresetn is low.
`ifndef USART_REGISTER_MODEL_ASSERT_SVH
`define USART_REGISTER_MODEL_ASSERT_SVH

// Same-cycle implication, ignored while reset is held
`define URM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("usart register model: implication check failed");

// Next-cycle implication, ignored while reset is held
`define URM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("usart register model: next-cycle check failed");

`endif

FILE: src/urm_pkg.sv
`default_nettype none

package urm_pkg;

    // Operation codes carried on the request channel
    typedef enum logic [2:0] {
        FUNC_RD_DATA   = 3'd0,
        FUNC_RD_STATUS = 3'd1,
        FUNC_WR_DATA   = 3'd2,
        FUNC_WR_CTRL   = 3'd3,
        FUNC_RX_BYTE   = 3'd4,
        FUNC_TICK      = 3'd5
    } urm_func_t;

    // Control port setup sequence
    typedef enum logic [1:0] {
        PH_MODE  = 2'd0,
        PH_SYNC1 = 2'd1,
        PH_SYNC2 = 2'd2,
        PH_CMD   = 2'd3
    } urm_phase_t;

    localparam int TICK_W = 10;

    // Status bit positions
    localparam int STS_TX_READY = 0;
    localparam int STS_RX_READY = 1;
    localparam int STS_TX_EMPTY = 2;
    localparam int ST_OE      = 4;
    localparam logic [7:0] ST_ERR_MASK = 8'h38;
    localparam logic [7:0] ST_RESET    = 8'h05;

    // Command bit positions
    localparam int CM_TXEN   = 0;
    localparam int CM_DTR    = 1;
    localparam int CM_RXE    = 2;
    localparam int CM_RSTERR = 4;
    localparam int CM_RTS    = 5;
    localparam int CM_IRESET = 6;

    typedef struct packed {
        urm_func_t  func;
        logic [7:0] wdata;
        logic       dsr_in;
    } urm_req_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_ready_line;
        logic       rts_out;
        logic       dtr_out;
        logic       line_change;
        logic [3:0] data_bits;
        logic [2:0] stop_code;
        logic [1:0] parity_kind;
    } urm_result_t;

    // Stop setting in half bits: invalid, one, one and a half, two
    function automatic logic [2:0] urm_stop_code(input logic [7:0] mode);
        logic [2:0] code;
        case (mode[7:6])
            2'd0:    code = 3'd0;
            2'd1:    code = 3'd2;
            2'd2:    code = 3'd3;
            default: code = 3'd4;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] urm_parity_kind(input logic [7:0] mode);
        return mode[4] ? (mode[5] ? 2'd2 : 2'd1) : 2'd0;
    endfunction

    function automatic logic [3:0] urm_data_bits(input logic [7:0] mode);
        return 4'd5 + {2'b00, mode[3:2]};
    endfunction

    // Character length in reference ticks; the rate factor is a shift
    function automatic logic [TICK_W-1:0] urm_char_ticks(input logic [7:0] mode);
        logic [4:0]        halves;
        logic [TICK_W-1:0] ticks;
        halves = 5'd2 * (5'd1 + {1'b0, urm_data_bits(mode)} + {4'd0, mode[4]})
               + {2'b00, urm_stop_code(mode)};
        case (mode[1:0])
            2'd2:    ticks = {2'b00, halves, 3'b000};
            2'd3:    ticks = {halves, 5'b00000};
            default: ticks = {6'd0, halves[4:1]};
        endcase
        return ticks;
    endfunction

endpackage

`default_nettype wire

FILE: src/urm_core.sv
`default_nettype none

// Register state of the USART and the per-request update
module urm_core (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  step,
    input  wire urm_pkg::urm_req_t req,
    output urm_pkg::urm_result_t res
);

    logic [7:0]                 status_reg, status_next;
    logic [7:0]                 command_reg, command_next;
    logic [7:0]                 mode_reg, mode_next;
    urm_pkg::urm_phase_t        phase_reg, phase_next;
    logic [urm_pkg::TICK_W-1:0] char_ticks_reg, char_ticks_next;
    logic [7:0]                 shift_reg, shift_next;
    logic [7:0]                 hold_reg, hold_next;
    logic [7:0]                 rx_buffer_reg, rx_buffer_next;
    logic [urm_pkg::TICK_W-1:0] countdown_reg, countdown_next;
    logic                       timer_on_reg, timer_on_next;
    logic                       rx_line_reg, rx_line_next;
    logic [urm_pkg::TICK_W-1:0] count_dec;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg     <= urm_pkg::ST_RESET;
            command_reg    <= '0;
            mode_reg       <= '0;
            phase_reg      <= urm_pkg::PH_MODE;
            char_ticks_reg <= '0;
            shift_reg      <= '0;
            hold_reg       <= '0;
            rx_buffer_reg  <= '0;
            countdown_reg  <= '0;
            timer_on_reg   <= 1'b0;
            rx_line_reg    <= 1'b0;
        end else if (step) begin
            status_reg     <= status_next;
            command_reg    <= command_next;
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            char_ticks_reg <= char_ticks_next;
            shift_reg      <= shift_next;
            hold_reg       <= hold_next;
            rx_buffer_reg  <= rx_buffer_next;
            countdown_reg  <= countdown_next;
            timer_on_reg   <= timer_on_next;
            rx_line_reg    <= rx_line_next;
        end
    end

    // Next state and result for the request in hand
    always_comb begin
        status_next     = status_reg;
        command_next    = command_reg;
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        char_ticks_next = char_ticks_reg;
        shift_next      = shift_reg;
        hold_next       = hold_reg;
        rx_buffer_next  = rx_buffer_reg;
        countdown_next  = countdown_reg;
        timer_on_next   = timer_on_reg;
        rx_line_next    = rx_line_reg;
        count_dec       = (countdown_reg != '0) ? countdown_reg - 1'b1 : countdown_reg;
        res             = '0;

        case (req.func)
            urm_pkg::FUNC_RD_DATA: begin
                status_next[urm_pkg::STS_RX_READY] = 1'b0;
                rx_line_next = 1'b0;
                res.rdata    = rx_buffer_reg;
            end
            urm_pkg::FUNC_RD_STATUS: begin
                res.rdata = {status_reg[7] | req.dsr_in, status_reg[6:0]};
            end
            urm_pkg::FUNC_WR_DATA: begin
                if (command_reg[urm_pkg::CM_TXEN]) begin
                    if (status_reg[urm_pkg::STS_TX_EMPTY]) begin
                        status_next[urm_pkg::STS_TX_EMPTY] = 1'b0;
                        shift_next     = req.wdata;
                        countdown_next = char_ticks_reg;
                        timer_on_next  = 1'b1;
                    end else begin
                        hold_next = req.wdata;
                        status_next[urm_pkg::STS_TX_READY] = 1'b0;
                    end
                end
            end
            urm_pkg::FUNC_WR_CTRL: begin
                case (phase_reg)
                    urm_pkg::PH_MODE: begin
                        mode_next       = req.wdata;
                        char_ticks_next = urm_pkg::urm_char_ticks(req.wdata);
                        phase_next = (req.wdata[1:0] == 2'd0) ? urm_pkg::PH_SYNC1
                                                              : urm_pkg::PH_CMD;
                    end
                    // sync characters only steer the sequence here
                    urm_pkg::PH_SYNC1: begin
                        phase_next = mode_reg[7] ? urm_pkg::PH_CMD : urm_pkg::PH_SYNC2;
                    end
                    urm_pkg::PH_SYNC2: begin
                        phase_next = urm_pkg::PH_CMD;
                    end
                    default: begin
                        if (req.wdata[urm_pkg::CM_IRESET]) begin
                            phase_next = urm_pkg::PH_MODE;
                        end else begin
                            command_next = req.wdata;
                            if (!req.wdata[urm_pkg::CM_TXEN]) begin
                                timer_on_next = 1'b0;
                                status_next[urm_pkg::STS_TX_READY] = 1'b1;
                                status_next[urm_pkg::STS_TX_EMPTY] = 1'b1;
                            end
                            if (req.wdata[urm_pkg::CM_RSTERR]) begin
                                status_next = status_next & ~urm_pkg::ST_ERR_MASK;
                            end
                            // receive enable toggled
                            if (req.wdata[urm_pkg::CM_RXE] != command_reg[urm_pkg::CM_RXE]) begin
                                status_next = status_next & ~urm_pkg::ST_ERR_MASK;
                                if (!req.wdata[urm_pkg::CM_RXE]) begin
                                    status_next[urm_pkg::STS_RX_READY] = 1'b0;
                                end
                                res.line_change = 1'b1;
                            end
                        end
                    end
                endcase
            end
            urm_pkg::FUNC_RX_BYTE: begin
                if (status_reg[urm_pkg::STS_RX_READY]) begin
                    status_next[urm_pkg::ST_OE] = 1'b1;
                end else begin
                    rx_buffer_next = req.wdata;
                    status_next[urm_pkg::STS_RX_READY] = 1'b1;
                    rx_line_next = 1'b1;
                end
            end
            urm_pkg::FUNC_TICK: begin
                if (timer_on_reg) begin
                    countdown_next = count_dec;
                    if (count_dec == '0) begin
                        res.tx_valid  = 1'b1;
                        res.tx_byte   = shift_reg;
                        timer_on_next = 1'b0;
                        if (status_reg[urm_pkg::STS_TX_READY]) begin
                            status_next[urm_pkg::STS_TX_EMPTY] = 1'b1;
                        end else begin
                            // hold byte moves into the shifter
                            status_next[urm_pkg::STS_TX_READY] = 1'b1;
                            status_next[urm_pkg::STS_TX_EMPTY] = 1'b0;
                            shift_next     = hold_reg;
                            countdown_next = char_ticks_reg;
                            timer_on_next  = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // Lines and mode fields reflect the state after the request
        res.rx_ready_line = rx_line_next;
        res.rts_out       = command_next[urm_pkg::CM_RTS];
        res.dtr_out       = command_next[urm_pkg::CM_DTR];
        res.data_bits     = urm_pkg::urm_data_bits(mode_next);
        res.stop_code     = urm_pkg::urm_stop_code(mode_next);
        res.parity_kind   = urm_pkg::urm_parity_kind(mode_next);
    end

endmodule

`default_nettype wire

FILE: src/usart_register_model.sv
// Channel  | Direction | Handshake          | Payload
// request  | in        | s_valid / s_ready  | s_func, s_wdata, s_dsr_in
// result   | out       | m_valid / m_ready  | m_rdata .. m_parity_kind
//
// One request per cycle sustained while m_ready stays high. A request passes
// the input register, then the result register: it is applied once the
// result register is free, and its result is captured with m_valid set.
// Synchronous active-low reset: status reads 0x05, setup awaits a mode word.
// A stalled result holds in the output register while the input register
// still takes one request; s_ready drops only when both are full.
`default_nettype none

`include "usart_register_model_assert.svh"

module usart_register_model (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [2:0] s_func,
    input  wire  [7:0] s_wdata,
    input  wire        s_dsr_in,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_rdata,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic       m_rx_ready_line,
    output logic       m_rts_out,
    output logic       m_dtr_out,
    output logic       m_line_change,
    output logic [3:0] m_data_bits,
    output logic [2:0] m_stop_code,
    output logic [1:0] m_parity_kind
);

    logic                 in_valid_reg;
    urm_pkg::urm_req_t    in_req_reg;
    logic                 out_valid_reg;
    urm_pkg::urm_result_t out_res_reg;
    urm_pkg::urm_result_t core_res;
    logic                 out_free;
    logic                 advance;

    // Pipeline control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg.func   <= urm_pkg::urm_func_t'(s_func);
            in_req_reg.wdata  <= s_wdata;
            in_req_reg.dsr_in <= s_dsr_in;
        end
    end

    urm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .req     (in_req_reg),
        .res     (core_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_rdata         = out_res_reg.rdata;
    assign m_tx_valid      = out_res_reg.tx_valid;
    assign m_tx_byte       = out_res_reg.tx_byte;
    assign m_rx_ready_line = out_res_reg.rx_ready_line;
    assign m_rts_out       = out_res_reg.rts_out;
    assign m_dtr_out       = out_res_reg.dtr_out;
    assign m_line_change   = out_res_reg.line_change;
    assign m_data_bits     = out_res_reg.data_bits;
    assign m_stop_code     = out_res_reg.stop_code;
    assign m_parity_kind   = out_res_reg.parity_kind;

    // Checks
    `URM_ASSERT_IMPL(a_tx_not_with_change, m_valid && m_tx_valid, !m_line_change && m_rdata == 8'd0)
    `URM_ASSERT_IMPL(a_full_blocks_input, in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    `URM_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg)
    `URM_ASSERT_IMPL(a_data_bits_sane, m_valid, m_data_bits >= 4'd5)
    `URM_ASSERT_IMPL(a_stop_parity_sane, m_valid, m_stop_code != 3'd1 && m_parity_kind != 2'd3)

endmodule

`default_nettype wire
